// File: rtl/core/unsorted_record_table_top_macros.svh
// Assertion macros for the unsorted record table.
// Taken in by the top level, which supplies clk and rst_n in scope.
`ifndef UNSORTED_RECORD_TABLE_TOP_MACROS_SVH
`define UNSORTED_RECORD_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define URT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/urt_pkg.sv
// Package for the unsorted record table: record type, command and status codes.
// Used by urt_cell and unsorted_record_table_top; depends on nothing.
package urt_pkg;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] value;
    logic [63:0] name;
  } rec_t;

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_RETRIEVE = 3'd1;
  localparam logic [2:0] CMD_DELETE   = 3'd2;
  localparam logic [2:0] CMD_GET_NEXT = 3'd3;
  localparam logic [2:0] CMD_RST_CUR  = 3'd4;
  localparam logic [2:0] CMD_EMPTY    = 3'd5;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_END       = 3'd4;

endpackage

// File: rtl/core/urt_cell.sv
// One storage cell of the record ring: holds one record and takes its
// neighbor's record whenever the ring rotates. Depends on urt_pkg.
module urt_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  urt_pkg::rec_t rec_in,
  output urt_pkg::rec_t rec_out
);
  import urt_pkg::*;

  rec_t rec_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      rec_r <= rec_in;
    end
  end

  assign rec_out = rec_r;

endmodule

// File: rtl/core/unsorted_record_table_top.sv
// Unsorted record table: a ring of DEPTH record cells that rotates past one head cell.
// A request that walks the ring (insert below full, retrieve or delete in a non-empty
// table, get-next before the end) rotates it once through all DEPTH cells. Delete of a
// present key walks a second time to fill its slot with the last record; others skip the walk.
// One request is in work at a time; the next is accepted once the result is loaded into the output register.
// Synchronous reset clears the count, cursor and control; record cells are not cleared.
module unsorted_record_table_top #(
  parameter int DEPTH = 16,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    in_cmd,
  input  logic [31:0]   in_key,
  input  logic [15:0]   in_value,
  input  logic [63:0]   in_name_tag,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_status,
  output logic [31:0]   out_rec_key,
  output logic [15:0]   out_rec_value,
  output logic [63:0]   out_rec_name,
  output logic [CW-1:0] out_entry_count,
  output logic          out_is_full
);
  import urt_pkg::*;
  `include "unsorted_record_table_top_macros.svh"

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIX, S_RESP} state_t;

  state_t        state_r;
  logic [2:0]    cmd_r;
  logic [31:0]   key_r;
  logic [15:0]   value_r;
  logic [63:0]   name_r;
  logic [IW-1:0] step_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] cursor_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  rec_t          last_rec_r;
  rec_t          res_rec_r;
  logic [2:0]    res_status_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  rec_t          out_rec_r;
  logic [CW-1:0] out_count_r;
  logic          out_full_r;

  rec_t          cell_in  [DEPTH];
  rec_t          cell_rec [DEPTH];
  rec_t          head;
  rec_t          wr_rec;
  logic          wr_en;
  logic          rotate;
  logic [CW-1:0] step_ext;
  logic          step_last;
  logic          key_hit;
  logic          hit_nxt;
  logic          out_free;
  logic          out_load;

  assign rotate = (state_r == S_SCAN) || (state_r == S_FIX);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      assign cell_in[i] = wr_en ? wr_rec : cell_rec[0];
    end else begin : g_body
      assign cell_in[i] = cell_rec[i + 1];
    end
    urt_cell u_cell (
      .clk      (clk),
      .shift_en (rotate),
      .rec_in   (cell_in[i]),
      .rec_out  (cell_rec[i])
    );
  end

  always_comb begin
    head      = cell_rec[0];
    step_ext  = CW'(step_r);
    step_last = (step_r == IW'(DEPTH - 1));
    key_hit   = (step_ext < count_r) && (head.key == key_r);
    hit_nxt   = hit_r || key_hit;
    wr_en     = ((state_r == S_SCAN) && (cmd_r == CMD_INSERT) && (step_ext == count_r)) ||
                ((state_r == S_FIX) && (step_r == hit_idx_r));
    wr_rec    = (state_r == S_FIX) ? last_rec_r : rec_t'{key_r, value_r, name_r};
    out_free  = !out_valid_r || !out_stall;
    out_load  = (state_r == S_RESP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r     <= in_cmd;
            key_r     <= in_key;
            value_r   <= in_value;
            name_r    <= in_name_tag;
            step_r    <= '0;
            hit_r     <= 1'b0;
            res_rec_r <= '0;
            unique case (in_cmd)
              CMD_INSERT: begin
                if (count_r == CW'(DEPTH)) begin
                  res_status_r <= ST_FULL;
                  state_r      <= S_RESP;
                end else begin
                  res_status_r <= ST_DONE;
                  state_r      <= S_SCAN;
                end
              end
              CMD_RETRIEVE, CMD_DELETE: begin
                if (count_r == '0) begin
                  res_status_r <= ST_NOT_FOUND;
                  state_r      <= S_RESP;
                end else begin
                  res_status_r <= ST_DONE;
                  state_r      <= S_SCAN;
                end
              end
              CMD_GET_NEXT: begin
                if (cursor_r >= count_r) begin
                  res_status_r <= ST_END;
                  state_r      <= S_RESP;
                end else begin
                  res_status_r <= ST_DONE;
                  state_r      <= S_SCAN;
                end
              end
              CMD_RST_CUR: begin
                res_status_r <= ST_DONE;
                state_r      <= S_RESP;
                cursor_r     <= '0;
              end
              CMD_EMPTY: begin
                res_status_r <= ST_DONE;
                state_r      <= S_RESP;
                cursor_r     <= '0;
                count_r      <= '0;
              end
              default: begin
                res_status_r <= ST_DONE;
                state_r      <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          step_r <= step_last ? '0 : step_r + 1'b1;
          unique case (cmd_r)
            CMD_RETRIEVE: begin
              if (!hit_r && key_hit) begin
                hit_r     <= 1'b1;
                res_rec_r <= head;
              end
              if (step_last) begin
                res_status_r <= hit_nxt ? ST_FOUND : ST_NOT_FOUND;
              end
            end
            CMD_DELETE: begin
              if (!hit_r && key_hit) begin
                hit_r     <= 1'b1;
                hit_idx_r <= step_r;
              end
              if (step_ext == count_r - 1'b1) begin
                last_rec_r <= head;
              end
              if (step_last && !hit_nxt) begin
                res_status_r <= ST_NOT_FOUND;
              end
            end
            CMD_GET_NEXT: begin
              if (step_ext == cursor_r) begin
                res_rec_r <= head;
              end
              if (step_last) begin
                cursor_r <= cursor_r + 1'b1;
              end
            end
            default: begin
              if (step_last) begin
                count_r <= count_r + 1'b1;
              end
            end
          endcase
          if (step_last) begin
            state_r <= ((cmd_r == CMD_DELETE) && hit_nxt) ? S_FIX : S_RESP;
          end
        end
        S_FIX: begin
          step_r <= step_last ? '0 : step_r + 1'b1;
          if (step_last) begin
            count_r <= count_r - 1'b1;
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_rec_r    <= res_rec_r;
            out_count_r  <= count_r;
            out_full_r   <= (count_r == CW'(DEPTH));
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_rec_key     = out_rec_r.key;
  assign out_rec_value   = out_rec_r.value;
  assign out_rec_name    = out_rec_r.name;
  assign out_entry_count = out_count_r;
  assign out_is_full     = out_full_r;

  `URT_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "Record count exceeds depth.")
  `URT_ASSERT_SAME(a_fix_slot, state_r == S_FIX, CW'(hit_idx_r) < count_r, "Delete slot is not held.")
  `URT_ASSERT_NEXT(a_resp_load, (state_r == S_RESP) && out_free, out_valid && !rotate, "Result was not loaded.")

endmodule

// File: test/unsorted_record_table_top_tb.sv
// Testbench for unsorted_record_table_top: directed and random command traffic.
// Keeps its own copy of the record table to predict every result.
// Depends on urt_pkg and the unsorted_record_table_top RTL.
`timescale 1ns / 1ps

module unsorted_record_table_top_tb;
  import urt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] key;
    logic [15:0] value;
    logic [63:0] name;
    logic [CW-1:0] count;
    logic        full;
  } table_answer_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [2:0]    in_cmd = CMD_INSERT;
  logic [31:0]   in_key = '0;
  logic [15:0]   in_value = '0;
  logic [63:0]   in_name_tag = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [2:0]    out_status;
  logic [31:0]   out_rec_key;
  logic [15:0]   out_rec_value;
  logic [63:0]   out_rec_name;
  logic [CW-1:0] out_entry_count;
  logic          out_is_full;

  logic [31:0] table_key [TABLE_DEPTH];
  logic [15:0] table_value [TABLE_DEPTH];
  logic [63:0] table_name [TABLE_DEPTH];
  int table_count = 0;
  int table_cursor = 0;

  table_answer_t pending_answers[$];
  bit idle_on = 1'b0;
  int stall_left = 0;
  int n_requests = 0;
  int n_answers = 0;
  int n_errors = 0;
  int cycle_count = 0;
  int status_seen [5] = '{default: 0};

  unsorted_record_table_top #(.DEPTH(TABLE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_key(in_key),
    .in_value(in_value), .in_name_tag(in_name_tag),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_rec_key(out_rec_key), .out_rec_value(out_rec_value),
    .out_rec_name(out_rec_name), .out_entry_count(out_entry_count),
    .out_is_full(out_is_full)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** unsorted_record_table_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", n_answers, msg);
    n_errors++;
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
  endtask

  always @(posedge clk) begin
    table_answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_answers.pop_front();
        check_field("status", 64'(out_status), 64'(want.status));
        check_field("rec_key", 64'(out_rec_key), 64'(want.key));
        check_field("rec_value", 64'(out_rec_value), 64'(want.value));
        check_field("rec_name", out_rec_name, want.name);
        check_field("entry_count", 64'(out_entry_count), 64'(want.count));
        check_field("is_full", 64'(out_is_full), 64'(want.full));
        if (want.status <= ST_END) status_seen[want.status]++;
      end
      n_answers++;
    end
  end

  task automatic predict_table(input logic [2:0] cmd, input logic [31:0] key,
                               input logic [15:0] value, input logic [63:0] name);
    table_answer_t ans;
    int slot;
    ans = '{status: ST_DONE, key: '0, value: '0, name: '0, count: '0, full: 1'b0};
    slot = -1;
    for (int i = table_count - 1; i >= 0; i--) begin
      if (table_key[i] == key) slot = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (table_count >= TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          table_key[table_count] = key;
          table_value[table_count] = value;
          table_name[table_count] = name;
          table_count++;
        end
      end
      CMD_RETRIEVE: begin
        if (slot >= 0) begin
          ans.status = ST_FOUND;
          ans.key = table_key[slot];
          ans.value = table_value[slot];
          ans.name = table_name[slot];
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      CMD_DELETE: begin
        if (slot >= 0) begin
          table_key[slot] = table_key[table_count - 1];
          table_value[slot] = table_value[table_count - 1];
          table_name[slot] = table_name[table_count - 1];
          table_count--;
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      CMD_GET_NEXT: begin
        if (table_cursor < table_count) begin
          ans.key = table_key[table_cursor];
          ans.value = table_value[table_cursor];
          ans.name = table_name[table_cursor];
          table_cursor++;
        end else begin
          ans.status = ST_END;
        end
      end
      CMD_RST_CUR: begin
        table_cursor = 0;
      end
      CMD_EMPTY: begin
        table_count = 0;
        table_cursor = 0;
      end
      default: begin
      end
    endcase
    ans.count = CW'(table_count);
    ans.full = (table_count == TABLE_DEPTH);
    pending_answers.push_back(ans);
  endtask

  task automatic send_request(input logic [2:0] cmd, input logic [31:0] key,
                              input logic [15:0] value, input logic [63:0] name);
    int gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_key <= key;
    in_value <= value;
    in_name_tag <= name;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table(cmd, key, value, name);
    n_requests++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_answers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && table_count > 0) return table_key[$urandom_range(0, table_count - 1)];
    if (r < 8) return 32'($urandom_range(0, 15));
    if (r == 8) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_name();
    case ($urandom_range(0, 7))
      0: return 64'h0;
      1: return {64{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_empty_table();
    send_request(CMD_GET_NEXT, 32'h0, 16'h0, 64'h0);
    send_request(CMD_DELETE, 32'h5, 16'h0, 64'h0);
  endtask

  task automatic test_fill_to_full();
    send_request(CMD_INSERT, 32'h0, 16'h0000, 64'h0);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, {64{1'b1}});
    send_request(CMD_INSERT, 32'h1234, 16'd9950, "SAMPLE A");
    for (int i = 3; i < TABLE_DEPTH - 1; i++)
      send_request(CMD_INSERT, 32'(100 + i), pick_value(), pick_name());
    send_request(CMD_INSERT, 32'h1234, 16'd4210, "DUPLICAT");
    send_request(CMD_INSERT, 32'h7777, 16'h1, "OVERFLOW");
  endtask

  task automatic test_lookup();
    send_request(CMD_RETRIEVE, 32'h1234, 16'h0, 64'h0);
    send_request(CMD_RETRIEVE, 32'hDEAD_BEEF, 16'h0, 64'h0);
  endtask

  task automatic test_cursor_walk();
    send_request(CMD_GET_NEXT, 32'h0, 16'h0, 64'h0);
    send_request(CMD_GET_NEXT, 32'h0, 16'h0, 64'h0);
    send_request(CMD_RST_CUR, 32'h0, 16'h0, 64'h0);
  endtask

  task automatic test_delete();
    send_request(CMD_DELETE, 32'h0, 16'h0, 64'h0);
    send_request(CMD_DELETE, 32'h0, 16'h0, 64'h0);
    send_request(CMD_RETRIEVE, 32'h1234, 16'h0, 64'h0);
  endtask

  task automatic test_unused_and_empty();
    send_request(CMD_UNUSED_6, 32'h1234, 16'hFFFF, {64{1'b1}});
    send_request(CMD_UNUSED_7, 32'h1234, 16'hFFFF, {64{1'b1}});
    send_request(CMD_EMPTY, 32'h0, 16'h0, 64'h0);
    send_request(CMD_GET_NEXT, 32'h0, 16'h0, 64'h0);
  endtask

  task automatic test_random_traffic(input int n_items, input int ins_pct, input int empty_pct);
    int r;
    logic [2:0] cmd;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) cmd = CMD_INSERT;
      else if (r < ins_pct + 20) cmd = CMD_RETRIEVE;
      else if (r < ins_pct + 35) cmd = CMD_DELETE;
      else if (r < ins_pct + 53) cmd = CMD_GET_NEXT;
      else if (r < ins_pct + 58) cmd = CMD_RST_CUR;
      else if (r < ins_pct + 58 + empty_pct) cmd = CMD_EMPTY;
      else cmd = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
      send_request(cmd, pick_key(), pick_value(), pick_name());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_fill_to_full();
    test_lookup();
    test_cursor_walk();
    test_delete();
    test_unused_and_empty();
    idle_on = 1'b1;
    test_random_traffic(500, 35, 3);
    wait_for_answers();
    test_random_traffic(400, 50, 1);
    test_random_traffic(300, 25, 8);
    idle_on = 1'b0;
    test_random_traffic(150, 35, 3);
    wait_for_answers();
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
    $display("Sent %0d requests and checked %0d results with %0d mismatches.",
             n_requests, n_answers, n_errors);
    $display("Statuses seen: done %0d, found %0d, not found %0d, full %0d, end of list %0d.",
             status_seen[ST_DONE], status_seen[ST_FOUND], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], status_seen[ST_END]);
    if (n_errors == 0) begin
      $display("** unsorted_record_table_top: PASSED **");
    end else begin
      $display("** unsorted_record_table_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/urt_pkg.sv
rtl/core/urt_cell.sv
rtl/core/unsorted_record_table_top.sv
test/unsorted_record_table_top_tb.sv
